>>> rtl/core/pid_controller_step_unit_assert.svh
// Assertion macros for the PID step unit; each expects clk and rst in scope.
`ifndef PID_CONTROLLER_STEP_UNIT_ASSERT_SVH
`define PID_CONTROLLER_STEP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PIDCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PIDCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PIDCS_ASSERT_IMP(lbl, ante, cons, msg)
`define PIDCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/pidcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pidcs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ERR_W      = DATA_WIDTH + 1;
  localparam int DERR_W     = DATA_WIDTH + 2;
  localparam int INT_W      = DATA_WIDTH + 16;
  localparam int INC_W      = INT_W + 2;
  localparam int ISUM_W     = INC_W + 1;
  localparam int DIG_W      = 16;
  localparam int N_DIG      = INT_W / DIG_W;
  localparam int DIG_CNT_W  = 2;
  localparam int PP_W       = DIG_W + DATA_WIDTH;
  localparam int ACC_W      = INT_W + DATA_WIDTH;
  localparam int SHIFT_W    = ACC_W - FRAC_BITS;
  localparam int TERM_W     = 63;
  localparam int SUM_W      = 64;
  localparam int DVD_W      = 2 * DATA_WIDTH + 1;
  localparam int QCNT_W     = 7;
  localparam logic [SUM_W-1:0] TERM_CAP = SUM_W'(1) << 61;

  typedef enum logic [1:0] {
    MODE_TIMED    = 2'd0,
    MODE_DISCRETE = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_NOP      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_KP = 2'd0,
    CFG_KI = 2'd1,
    CFG_KD = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_P   = 2'd0,
    JOB_INC = 2'd1,
    JOB_I   = 2'd2,
    JOB_D   = 2'd3
  } job_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic [DIG_CNT_W-1:0] mul_dig;
    job_t                 job;
    logic                 term_wr;
    logic                 integ;
    logic                 div_start;
    logic                 div_wr;
    logic                 finish;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic ki_pos;
    logic kd_pos;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/pid_controller_step_unit.sv
// PID step unit, signed Q16.16, positional form.
// Input stream: one beat per step. tuser carries the mode (timed, discrete,
// clear, no-op); tdata carries setpoint, measurement and time step.
// Output stream: one beat per accepted input, control value in tdata and
// the clip flag in tuser.
// Config channel: write kp, ki, kd by index while the unit is idle; it is
// always ready.
// Clear and no-op beats finish fastest, a timed step with a nonzero time
// step slowest. The serial divider on the 65-bit dividend dominates; each
// product is built digit by digit from its 48-bit operand on the shared
// 16x32 digit multiplier, then written. One step is in flight at a time.
// A finished result sits in the output register, so the next input beat is
// taken while the receiver stalls; the unit only waits at the end of a step
// if the previous result is still not taken.
// Reset clears the gains, the integral and the previous error, and drops
// any pending output beat.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_step_unit_assert.svh"
module pid_controller_step_unit
  import pidcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] setpoint, [63:32] measurement, [95:64] time_step
  input  wire logic [95:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] control
  output logic [31:0]      m_axis_tdata,
  // [0] saturated
  output logic [0:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic signed [DATA_WIDTH-1:0] control;
  logic                         saturated;

  // the user must change gains only between steps; the block does not enforce it and takes every write at once
  assign cfg_ready = 1'b1;

  pidcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pidcs_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mode     (s_axis_tuser),
    .setpoint    (s_axis_tdata[31:0]),
    .measurement (s_axis_tdata[63:32]),
    .time_step   (s_axis_tdata[95:64]),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .control     (control),
    .saturated   (saturated)
  );

  assign m_axis_tdata = control;
  assign m_axis_tuser = saturated;

  // a finished step never overwrites a beat the receiver has not taken
  `PIDCS_ASSERT_IMP(a_out_no_overwrite, cmd.finish, !m_axis_tvalid || m_axis_tready, "result overwritten")
  // one step at a time: no new beat right after one is taken
  `PIDCS_ASSERT_NXT(a_single_step, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken")
  // the divider only runs inside a step
  `PIDCS_ASSERT_IMP(a_div_in_step, sts.div_busy, !s_axis_tready, "divider busy while idle")

endmodule
`default_nettype wire

>>> rtl/core/pidcs_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pidcs_div
  import pidcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DVD_W-1:0]      dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic      [DVD_W-1:0]      quotient,
  output logic                       busy,
  output logic                       done
);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dvs;
  logic [QCNT_W-1:0]     cnt;
  logic [DATA_WIDTH:0]   trial;
  logic                  ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem, quotient[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == QCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      cnt      <= QCNT_W'(DVD_W);
    end else if (busy) begin
      rem      <= ge ? DATA_WIDTH'(trial - {1'b0, dvs}) : trial[DATA_WIDTH-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
      cnt      <= cnt - QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/pidcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pidcs_ctrl
  import pidcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_mode,
  output logic            in_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MUL     = 8'b0000_0010,
    S_MWR     = 8'b0000_0100,
    S_INTEG   = 8'b0000_1000,
    S_DIVGO   = 8'b0001_0000,
    S_DIVWAIT = 8'b0010_0000,
    S_DIVWR   = 8'b0100_0000,
    S_SUM     = 8'b1000_0000
  } state_t;

  localparam logic [DIG_CNT_W-1:0] LAST_DIG = DIG_CNT_W'(N_DIG - 1);

  state_t               state, state_next;
  mode_t                mode, mode_next;
  job_t                 job, job_next;
  logic [DIG_CNT_W-1:0] dig, dig_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_NOP;
      job   <= JOB_P;
      dig   <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      job   <= job_next;
      dig   <= dig_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    job_next   = job;
    dig_next   = dig;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.job    = job;
    cmd.mul_dig = dig;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          mode_next = mode_t'(in_mode);
          if (mode_t'(in_mode) == MODE_TIMED || mode_t'(in_mode) == MODE_DISCRETE) begin
            job_next   = JOB_P;
            dig_next   = '0;
            state_next = S_MUL;
          end else begin
            state_next = S_SUM;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        dig_next   = dig + DIG_CNT_W'(1);
        if (dig == LAST_DIG) begin
          dig_next   = '0;
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        cmd.term_wr = 1'b1;
        case (job)
          JOB_P: begin
            if (mode == MODE_TIMED) begin
              job_next   = JOB_INC;
              state_next = S_MUL;
            end else begin
              state_next = S_INTEG;
            end
          end
          JOB_INC: state_next = S_INTEG;
          JOB_I: begin
            if (sts.dt_zero) begin
              state_next = S_SUM;
            end else begin
              job_next   = JOB_D;
              state_next = S_MUL;
            end
          end
          JOB_D: state_next = (mode == MODE_TIMED) ? S_DIVGO : S_SUM;
          default: state_next = S_SUM;
        endcase
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        if (mode == MODE_TIMED) begin
          job_next   = JOB_I;
          state_next = S_MUL;
        end else if (sts.ki_pos) begin
          state_next = S_DIVGO;
        end else if (sts.kd_pos) begin
          job_next   = JOB_D;
          state_next = S_MUL;
        end else begin
          state_next = S_SUM;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) begin
          state_next = S_DIVWR;
        end
      end
      S_DIVWR: begin
        cmd.div_wr = 1'b1;
        if (mode != MODE_TIMED && sts.kd_pos) begin
          job_next   = JOB_D;
          state_next = S_MUL;
        end else begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/pidcs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module pidcs_dpath
  import pidcs_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data,
  input  wire logic [1:0]                   in_mode,
  input  wire logic signed [DATA_WIDTH-1:0] setpoint,
  input  wire logic signed [DATA_WIDTH-1:0] measurement,
  input  wire logic [DATA_WIDTH-1:0]        time_step,
  input  wire cmd_t                         cmd,
  output sts_t                              sts,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      control,
  output logic                              saturated
);

  localparam logic signed [INT_W-1:0] IMAX = {1'b0, {(INT_W - 1){1'b1}}};
  localparam logic signed [INT_W-1:0] IMIN = {1'b1, {(INT_W - 1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] OMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] OMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] kp, ki, kd;
  mode_t                        mode;
  logic signed [ERR_W-1:0]      err, previous_error;
  logic [DATA_WIDTH-1:0]        dt;
  logic signed [INT_W-1:0]      integral_sum;
  logic signed [TERM_W-1:0]     p_term, i_term, d_term;
  logic signed [INC_W-1:0]      inc_term;
  logic [ACC_W-1:0]             acc;
  logic                         clip;

  logic signed [DERR_W-1:0] derr;
  logic [DATA_WIDTH-1:0]    kp_mag, ki_mag, kd_mag;
  logic [ERR_W-1:0]         err_mag;
  logic [DERR_W-1:0]        derr_mag;
  logic [INT_W-1:0]         int_mag;
  logic [INT_W-1:0]         mul_a;
  logic [DATA_WIDTH-1:0]    mul_b;
  logic                     mul_neg;
  logic [PP_W-1:0]          pp;
  logic [SHIFT_W-1:0]       shifted;
  logic                     term_clip;
  logic [SUM_W-1:0]         term_cap;
  logic [SUM_W-1:0]         term_val;
  logic [DVD_W-1:0]         dividend, quotient;
  logic [DATA_WIDTH-1:0]    divisor;
  logic                     q_clip, q_neg;
  logic [SUM_W-1:0]         q_cap, q_val;
  logic signed [INC_W-1:0]  inc_sel;
  logic signed [ISUM_W-1:0] isum;
  logic                     i_ovf;
  logic signed [INT_W-1:0]  int_sat;
  logic signed [SUM_W-1:0]  total;
  logic                     o_ovf;
  logic signed [DATA_WIDTH-1:0] o_sat;
  logic                     div_busy, div_done;

  assign derr     = DERR_W'(err) - DERR_W'(previous_error);
  assign kp_mag   = kp[DATA_WIDTH-1] ? ~kp + 1'b1 : kp;
  assign ki_mag   = ki[DATA_WIDTH-1] ? ~ki + 1'b1 : ki;
  assign kd_mag   = kd[DATA_WIDTH-1] ? ~kd + 1'b1 : kd;
  assign err_mag  = err[ERR_W-1] ? ~err + 1'b1 : err;
  assign derr_mag = derr[DERR_W-1] ? ~derr + 1'b1 : derr;
  assign int_mag  = integral_sum[INT_W-1] ? ~integral_sum + 1'b1 : integral_sum;

  // operand select for the shared digit multiplier
  always_comb begin
    case (cmd.job)
      JOB_P: begin
        mul_a   = INT_W'(err_mag);
        mul_b   = kp_mag;
        mul_neg = kp[DATA_WIDTH-1] ^ err[ERR_W-1];
      end
      JOB_INC: begin
        mul_a   = INT_W'(err_mag);
        mul_b   = dt;
        mul_neg = err[ERR_W-1];
      end
      JOB_I: begin
        mul_a   = int_mag;
        mul_b   = ki_mag;
        mul_neg = ki[DATA_WIDTH-1] ^ integral_sum[INT_W-1];
      end
      JOB_D: begin
        mul_a   = INT_W'(derr_mag);
        mul_b   = kd_mag;
        mul_neg = kd[DATA_WIDTH-1] ^ derr[DERR_W-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign pp = PP_W'(mul_a[DIG_W * int'(cmd.mul_dig) +: DIG_W]) * PP_W'(mul_b);

  // truncate toward zero, cap, then restore the sign
  assign shifted   = acc[ACC_W-1:FRAC_BITS];
  assign term_clip = SUM_W'(shifted) > TERM_CAP;
  assign term_cap  = term_clip ? TERM_CAP : SUM_W'(shifted);
  assign term_val  = mul_neg ? ~term_cap + 1'b1 : term_cap;

  assign dividend = (mode == MODE_TIMED) ? acc[DVD_W-1:0]
                                         : {1'b0, int_mag, {FRAC_BITS{1'b0}}};
  assign divisor  = (mode == MODE_TIMED) ? dt : ki;
  assign q_neg    = (mode == MODE_TIMED) ? (kd[DATA_WIDTH-1] ^ derr[DERR_W-1])
                                         : integral_sum[INT_W-1];
  assign q_clip   = quotient > DVD_W'(TERM_CAP);
  assign q_cap    = q_clip ? TERM_CAP : quotient[SUM_W-1:0];
  assign q_val    = q_neg ? ~q_cap + 1'b1 : q_cap;

  pidcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign inc_sel = (mode == MODE_TIMED) ? inc_term : INC_W'(err);
  assign isum    = ISUM_W'(integral_sum) + ISUM_W'(inc_sel);
  assign i_ovf   = (isum[ISUM_W-1:INT_W-1] != '0) && (isum[ISUM_W-1:INT_W-1] != '1);
  assign int_sat = i_ovf ? (isum[ISUM_W-1] ? IMIN : IMAX) : isum[INT_W-1:0];

  assign total = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
  assign o_ovf = (total[SUM_W-1:DATA_WIDTH-1] != '0) && (total[SUM_W-1:DATA_WIDTH-1] != '1);
  assign o_sat = o_ovf ? (total[SUM_W-1] ? OMIN : OMAX) : total[DATA_WIDTH-1:0];

  assign sts.dt_zero  = (dt == '0);
  assign sts.ki_pos   = !ki[DATA_WIDTH-1] && (ki != '0);
  assign sts.kd_pos   = !kd[DATA_WIDTH-1] && (kd != '0);
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp             <= '0;
      ki             <= '0;
      kd             <= '0;
      integral_sum   <= '0;
      previous_error <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KP:  kp <= cfg_data;
          CFG_KI:  ki <= cfg_data;
          CFG_KD:  kd <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && mode_t'(in_mode) == MODE_CLEAR) begin
        integral_sum   <= '0;
        previous_error <= '0;
      end
      if (cmd.integ) begin
        integral_sum <= int_sat;
      end
      if (cmd.finish && (mode == MODE_TIMED || mode == MODE_DISCRETE)) begin
        previous_error <= err;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode   <= mode_t'(in_mode);
      err    <= ERR_W'(setpoint) - ERR_W'(measurement);
      dt     <= time_step;
      p_term <= '0;
      i_term <= '0;
      d_term <= '0;
      clip   <= 1'b0;
    end
    if (cmd.mul_en) begin
      acc <= ((cmd.mul_dig == '0) ? '0 : acc) + (ACC_W'(pp) << (DIG_W * int'(cmd.mul_dig)));
    end
    if (cmd.term_wr) begin
      case (cmd.job)
        JOB_P:   p_term   <= TERM_W'(term_val);
        JOB_INC: inc_term <= INC_W'(term_val);
        JOB_I:   i_term   <= TERM_W'(term_val);
        JOB_D: begin
          if (mode != MODE_TIMED) begin
            d_term <= TERM_W'(term_val);
          end
        end
        default: ;
      endcase
      if (term_clip) begin
        clip <= 1'b1;
      end
    end
    if (cmd.integ && i_ovf) begin
      clip <= 1'b1;
    end
    if (cmd.div_wr) begin
      if (mode == MODE_TIMED) begin
        d_term <= TERM_W'(q_val);
      end else begin
        i_term <= TERM_W'(q_val);
      end
      if (q_clip) begin
        clip <= 1'b1;
      end
    end
    if (cmd.finish) begin
      control   <= o_sat;
      saturated <= clip | o_ovf;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the PID step unit: a cycle-free model of the Q16.16
// regulator predicts control value and clip flag for every accepted input
// beat; the output stream is checked in order against those predictions.
module tb;
  import pidcs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 120;   // longer than the slowest step
  localparam logic [63:0] CAP_TERM = 64'd1 << 61;
  localparam logic [63:0] CAP_INC  = (64'd1 << 63) - 64'd1;
  localparam logic signed [65:0] INTEG_MAX = (66'sd1 <<< 47) - 66'sd1;
  localparam logic signed [65:0] INTEG_MIN = -(66'sd1 <<< 47);
  localparam logic signed [65:0] CTRL_MAX  = 66'sd2147483647;
  localparam logic signed [65:0] CTRL_MIN  = -66'sd2147483648;

  typedef struct packed {
    logic [31:0] control;
    logic        saturated;
  } ctrl_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // [31:0] setpoint, [63:32] measurement, [95:64] time_step
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] control
  logic [0:0]  m_axis_tuser;        // [0] saturated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pid_controller_step_unit DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Regulator state as the block should hold it.
  logic signed [63:0] gain_p, gain_i, gain_d;
  logic signed [63:0] integ_acc, last_err;
  bit                 step_clip;

  ctrl_result_t expected_q[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  beats_sent = 0;
  int  mode_count[4];
  int  sat_count = 0;
  bit  no_idle = 1'b0;   // both sides run flat out while set, unless a hold-off is counting down
  int  hold_off = 0;     // receiver stall, counted down in its own process
  int  cycles = 0;

  function automatic logic [63:0] magnitude(logic signed [63:0] a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // (a*b) >> FRAC_BITS with the magnitude truncated, clipped to +-cap
  function automatic logic signed [63:0] fixed_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b,
                                                   logic [63:0] cap);
    logic [127:0] prod;
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    prod = prod >> FRAC_BITS;
    if (prod > {64'd0, cap}) begin
      step_clip = 1'b1;
      prod = {64'd0, cap};
    end
    return ((a < 0) != (b < 0)) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // exact unsigned quotient with the magnitude clipped to the term cap
  function automatic logic [63:0] capped_quot(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    q = num / {64'd0, den};
    if (q > {64'd0, CAP_TERM}) begin
      step_clip = 1'b1;
      q = {64'd0, CAP_TERM};
    end
    return q[63:0];
  endfunction

  function automatic void accumulate(logic signed [63:0] inc);
    logic signed [65:0] r;
    r = integ_acc + inc;
    if (r > INTEG_MAX) begin
      r = INTEG_MAX;
      step_clip = 1'b1;
    end else if (r < INTEG_MIN) begin
      r = INTEG_MIN;
      step_clip = 1'b1;
    end
    integ_acc = r[63:0];
  endfunction

  function automatic ctrl_result_t pid_step(mode_t mode, logic signed [31:0] sp,
                                            logic signed [31:0] ms, logic [31:0] dt);
    ctrl_result_t res;
    logic signed [63:0] err, derr, p, it, d;
    logic signed [65:0] total;
    logic [63:0] q;
    res = '0;
    if (mode == MODE_CLEAR) begin
      integ_acc = 0;
      last_err = 0;
      return res;
    end
    if (mode == MODE_NOP) return res;
    step_clip = 1'b0;
    err = sp;
    err = err - 64'(ms);
    derr = err - last_err;
    it = 0;
    d = 0;
    p = fixed_mul(gain_p, err, CAP_TERM);
    if (mode == MODE_TIMED) begin
      accumulate(fixed_mul(err, $signed({32'd0, dt}), CAP_INC));
      it = fixed_mul(gain_i, integ_acc, CAP_TERM);
      if (dt != 0) begin
        q = capped_quot({64'd0, magnitude(gain_d)} * {64'd0, magnitude(derr)}, {32'd0, dt});
        d = ((gain_d < 0) != (derr < 0)) ? -$signed(q) : $signed(q);
      end
    end else begin
      accumulate(err);
      if (gain_i > 0) begin
        q = capped_quot({64'd0, magnitude(integ_acc)} << FRAC_BITS, gain_i);
        it = (integ_acc < 0) ? -$signed(q) : $signed(q);
      end
      if (gain_d > 0) d = fixed_mul(gain_d, derr, CAP_TERM);
    end
    last_err = err;
    total = p;
    total = total + it + d;
    if (total > CTRL_MAX) begin
      total = CTRL_MAX;
      step_clip = 1'b1;
    end else if (total < CTRL_MIN) begin
      total = CTRL_MIN;
      step_clip = 1'b1;
    end
    res.control = total[31:0];
    res.saturated = step_clip;
    return res;
  endfunction

  // Check every output beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      ctrl_result_t want;
      results_seen++;
      if (m_axis_tuser[0]) sat_count++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: control=%h saturated=%b",
                   m_axis_tdata, m_axis_tuser[0]);
      end else begin
        want = expected_q.pop_front();
        if (want.control !== m_axis_tdata || want.saturated !== m_axis_tuser[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected control=%h saturated=%b, got control=%h saturated=%b",
                     results_seen, want.control, want.saturated, m_axis_tdata, m_axis_tuser[0]);
        end
      end
    end
  end

  // Receiver: random stalls, none while no_idle, and a long hold-off on request that applies even then.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_gain(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KP: gain_p = $signed(value);
      CFG_KI: gain_i = $signed(value);
      default: gain_d = $signed(value);
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd);
    write_gain(CFG_KP, kp);
    write_gain(CFG_KI, ki);
    write_gain(CFG_KD, kd);
  endtask

  // Send one step beat; idle first at random unless running flat out.
  // The unit drops ready right after every beat it takes, so the
  // closing cycle with valid low costs no throughput.
  task automatic send_step(mode_t mode, logic [31:0] sp, logic [31:0] ms, logic [31:0] dt);
    while (!no_idle && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {dt, ms, sp};
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(pid_step(mode, sp, ms, dt));
    mode_count[mode]++;
    beats_sent++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Let every expected result drain, so gains may change safely.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Values: mostly moderate Q16.16 numbers, sometimes full range or extremes.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_dt();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0002_0000, 1);
    endcase
  endfunction

  task automatic test_directed();
    set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
    send_step(MODE_TIMED, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_step(MODE_TIMED, 32'h0003_0000, 32'h0001_0000, 32'h0000_0000); // zero time step
    send_step(MODE_TIMED, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_step(MODE_TIMED, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_step(MODE_TIMED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_step(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_step(MODE_DISCRETE, 32'h0001_8000, 32'h0, 32'h0);
    send_step(MODE_DISCRETE, 32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF);
    send_step(MODE_NOP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA);
    send_step(MODE_DISCRETE, 32'h8000_0000, 32'h0, 32'h0);
    drain();
    // non-positive ki and kd: integral and derivative terms drop out in discrete mode
    set_gains(32'h0002_0000, 32'hFFFF_0000, 32'h0000_0000);
    send_step(MODE_DISCRETE, 32'h0004_0000, 32'h0, 32'h0);
    send_step(MODE_DISCRETE, 32'hFFFC_0000, 32'h0, 32'h0);
    drain();
    set_gains(32'h0, 32'h0, 32'hFFFF_0000);
    send_step(MODE_DISCRETE, 32'h0004_0000, 32'h0, 32'h0);
    send_step(MODE_TIMED, 32'h0004_0000, 32'hFFFF_0000, 32'h0000_0100);
    drain();
    // extreme gains: push every term and the integral into saturation
    set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (4) send_step(MODE_TIMED, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_step(MODE_DISCRETE, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_step(MODE_TIMED, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    drain();
    set_gains(32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
    send_step(MODE_DISCRETE, 32'h8000_0000, 32'h0, 32'h0);
    send_step(MODE_TIMED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    drain();
  endtask

  // One random phase: fresh gains, then runs of steps with occasional clears.
  task automatic test_random_phase(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                   int n);
    int r;
    set_gains(kp, ki, kd);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45)      send_step(MODE_TIMED, rand_value(), rand_value(), rand_dt());
      else if (r < 88) send_step(MODE_DISCRETE, rand_value(), 32'h0, $urandom);
      else if (r < 92) send_step(MODE_DISCRETE, rand_value(), rand_value(), $urandom);
      else if (r < 97) send_step(MODE_CLEAR, $urandom, $urandom, $urandom);
      else             send_step(MODE_NOP, $urandom, $urandom, $urandom);
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering beats, so the output
  // register and the step in flight fill and the input stalls.
  task automatic test_backpressure();
    hold_off = 600;
    no_idle = 1'b1;
    repeat (6) send_step(MODE_TIMED, rand_value(), rand_value(), rand_dt());
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    gain_p = 0; gain_i = 0; gain_d = 0;
    integ_acc = 0; last_err = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(32'h0000_8000, 32'h0000_0400, 32'h0000_1000, 90);
    test_random_phase($urandom, $urandom, $urandom, 80);
    no_idle = 1'b1;   // a stretch with no idling on either side
    test_random_phase(32'h0001_0000, 32'h0002_0000, 32'h0000_0100, 70);
    no_idle = 1'b0;
    test_backpressure();
    test_random_phase(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 70);
    test_random_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 70);
    test_random_phase(32'hFFFF_8000, 32'h0100_0000, 32'hFFFF_F000, 80);
    test_random_phase(32'h0, 32'h0, 32'h0, 50);
    drain();
    $display("run covered %0d steps (timed %0d, discrete %0d, clear %0d, no-op %0d)",
             beats_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("%0d results checked, %0d clipped, %0d mismatches, %0d cycles",
             results_seen, sat_count, mismatches, cycles);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
